// ===== hdl/kdf_pkg.sv =====
// ============================================================================
// kdf_pkg
// Shared types and constants for the key debounce event FIFO.
// ============================================================================
package kdf_pkg;

    localparam int KEY_COUNT      = 4;
    localparam int KEY_W          = 2;
    localparam int FIFO_DEPTH_DEF = 16;
    localparam int TICK_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 8;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_FILTER  = 2'd1;
    localparam logic [1:0] PH_PRESSED = 2'd2;
    localparam logic [1:0] PH_LONG    = 2'd3;

    localparam logic [1:0] EV_DOWN   = 2'd0;
    localparam logic [1:0] EV_UP     = 2'd1;
    localparam logic [1:0] EV_LONG   = 2'd2;
    localparam logic [1:0] EV_REPEAT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_KEYS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_EN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS = 3'd4;

    typedef struct packed {
        logic                 func;
        logic [KEY_COUNT-1:0] key_levels;
    } t_in_item;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] event_key;
        logic [1:0] event_kind;
    } t_out_item;

    typedef struct packed {
        logic [KEY_COUNT-1:0] active_level_mask;
        logic [KEY_COUNT-1:0] mask_keys;
        logic [KEY_COUNT-1:0] repeat_enable_mask;
        logic [TICK_W-1:0]    long_press_ticks;
        logic [TICK_W-1:0]    repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] key;
        logic [1:0] kind;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

endpackage

// ===== hdl/kdf_key_seq.sv =====
// ============================================================================
// kdf_key_seq
// Walks the keys one per cycle through a shared hold-count incrementer and
// compare, updating each key's debounce phase and emitting event pushes.
// ============================================================================
module kdf_key_seq
    import kdf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [KEY_COUNT-1:0] i_levels,
    input  t_cfg                 i_cfg,
    output logic                 o_busy,
    output t_push                o_push
);

    logic                 r_busy;
    logic [KEY_W-1:0]     r_key;
    logic [KEY_COUNT-1:0] r_levels;
    logic [KEY_COUNT-1:0] r_sample;
    logic [1:0]           r_phase [KEY_COUNT];
    logic [TICK_W-1:0]    r_hold  [KEY_COUNT];

    logic [1:0]        cur_phase;
    logic [1:0]        n_phase;
    logic [TICK_W-1:0] n_hold;
    logic [TICK_W-1:0] hold_inc;
    logic [TICK_W-1:0] limit;
    logic              down;
    logic              hit;
    logic              push_v;
    logic [1:0]        push_kind;

    always_comb begin
        cur_phase = r_phase[r_key];
        down      = i_cfg.mask_keys[r_key] ? r_sample[r_key]
                  : (r_levels[r_key] == i_cfg.active_level_mask[r_key]);
        hold_inc  = r_hold[r_key] + TICK_W'(1);
        limit     = (cur_phase == PH_PRESSED) ? i_cfg.long_press_ticks
                                              : i_cfg.repeat_ticks;
        hit       = (hold_inc >= limit);
        n_phase   = cur_phase;
        n_hold    = r_hold[r_key];
        push_v    = 1'b0;
        push_kind = EV_DOWN;
        unique case (cur_phase)
            PH_IDLE: begin
                if (down) n_phase = PH_FILTER;
            end
            PH_FILTER: begin
                if (down) begin
                    n_phase   = PH_PRESSED;
                    n_hold    = '0;
                    push_v    = 1'b1;
                    push_kind = EV_DOWN;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_PRESSED: begin
                if (!down) begin
                    n_phase   = PH_IDLE;
                    push_v    = 1'b1;
                    push_kind = EV_UP;
                end else if (hit) begin
                    n_phase   = PH_LONG;
                    n_hold    = '0;
                    push_v    = 1'b1;
                    push_kind = EV_LONG;
                end else begin
                    n_hold = hold_inc;
                end
            end
            PH_LONG: begin
                if (!down) begin
                    n_phase   = PH_IDLE;
                    push_v    = 1'b1;
                    push_kind = EV_UP;
                end else if (hit) begin
                    n_hold    = '0;
                    push_v    = i_cfg.repeat_enable_mask[r_key];
                    push_kind = EV_REPEAT;
                end else begin
                    n_hold = hold_inc;
                end
            end
        endcase
    end

    assign o_busy            = r_busy;
    assign o_push.valid      = r_busy && push_v;
    assign o_push.entry.key  = r_key;
    assign o_push.entry.kind = push_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_key    <= '0;
            r_sample <= '0;
            for (int k = 0; k < KEY_COUNT; k++) begin
                r_phase[k] <= PH_IDLE;
                r_hold[k]  <= '0;
            end
        end else if (r_busy) begin
            r_phase[r_key]  <= n_phase;
            r_hold[r_key]   <= n_hold;
            r_sample[r_key] <= down;
            r_key           <= r_key + KEY_W'(1);
            if (r_key == KEY_W'(KEY_COUNT - 1)) r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_key  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) r_levels <= i_levels;
    end

endmodule

// ===== hdl/kdf_event_fifo.sv =====
// ============================================================================
// kdf_event_fifo
// Ring buffer of key events; pushes into a full buffer are dropped.
// ============================================================================
module kdf_event_fifo
    import kdf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_empty,
    output t_entry o_rd_data
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_entry           r_mem [FIFO_DEPTH];
    t_entry           r_rd_data;
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_empty   = (r_cnt == '0);
    assign do_push   = i_push.valid && (r_cnt != CNT_W'(FIFO_DEPTH));
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wptr] <= i_push.entry;
        if (do_pop)  r_rd_data     <= r_mem[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
            end
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

// ===== hdl/key_debounce_event_fifo.sv =====
// ============================================================================
// key_debounce_event_fifo
// Debounced key scanner with long-press and repeat events and an event FIFO.
// ============================================================================
// A tick beat (func 0) is handled one key per cycle by a shared hold-count
// incrementer and compare and returns no result. A pop beat (func 1) keeps
// the block busy through the registered FIFO read and the output register
// (only the output register when the FIFO is empty), and while a previous
// result still waits at the output, and returns one result: the oldest
// event, or a beat with event_valid low when the FIFO is empty. Events
// arriving at a full FIFO are dropped. Configuration is written through a
// plain write port; the user must write it only while idle (unchecked).
module key_debounce_event_fifo
    import kdf_pkg::*;
#(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_POPD = 2'd3;

    logic [1:0] r_state;
    t_cfg       r_cfg;
    logic       r_out_valid;
    t_out_item  r_out_data;

    logic   in_beat;
    logic   start;
    logic   seq_busy;
    t_push  push;
    logic   slot_free;
    logic   fifo_empty;
    logic   pop;
    logic   out_load;
    t_entry rd_data;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign start       = in_beat && !i_in_data.func;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign pop         = (r_state == ST_POP) && slot_free && !fifo_empty;
    assign out_load    = ((r_state == ST_POP) && slot_free && fifo_empty)
                       || (r_state == ST_POPD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    kdf_key_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_levels (i_in_data.key_levels),
        .i_cfg    (r_cfg),
        .o_busy   (seq_busy),
        .o_push   (push)
    );

    kdf_event_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_pop     (pop),
        .o_empty   (fifo_empty),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_level_mask  <= KEY_COUNT'(8);
            r_cfg.mask_keys          <= '0;
            r_cfg.repeat_enable_mask <= KEY_COUNT'(15);
            r_cfg.long_press_ticks   <= TICK_W'(50);
            r_cfg.repeat_ticks       <= TICK_W'(5);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_ACTIVE_LEVEL: r_cfg.active_level_mask  <= i_cfg_data[KEY_COUNT-1:0];
                REG_MASK_KEYS:    r_cfg.mask_keys          <= i_cfg_data[KEY_COUNT-1:0];
                REG_REPEAT_EN:    r_cfg.repeat_enable_mask <= i_cfg_data[KEY_COUNT-1:0];
                REG_LONG_TICKS:   r_cfg.long_press_ticks   <= i_cfg_data[TICK_W-1:0];
                REG_REPEAT_TICKS: r_cfg.repeat_ticks       <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_beat) r_state <= i_in_data.func ? ST_POP : ST_SCAN;
                end
                ST_SCAN: begin
                    if (!seq_busy) r_state <= ST_IDLE;
                end
                ST_POP: begin
                    if (slot_free) begin
                        if (fifo_empty) begin
                            r_out_data <= '0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_state <= ST_POPD;
                        end
                    end
                end
                ST_POPD: begin
                    r_out_data.event_valid <= 1'b1;
                    r_out_data.event_key   <= rd_data.key;
                    r_out_data.event_kind  <= rd_data.kind;
                    r_state                <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
